[hw/rtl/tick_mask_task_scheduler_core_defines.svh]
// Assertion macros used by the scheduler tick unit.
`ifndef TICK_MASK_TASK_SCHEDULER_CORE_DEFINES_SVH
`define TICK_MASK_TASK_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TMTS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmts: same-cycle check failed");
`define TMTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmts: next-cycle check failed");
`else
`define TMTS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TMTS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tmts_pkg.sv]
package tmts_pkg;

    localparam int TIME_W        = 32;
    localparam int PERIOD_W      = 31;
    localparam int TICK_W        = 32;
    localparam int MAX_TASKS     = 4;
    localparam int NUM_TASKS_DEF = 4;
    localparam int TIDX_W        = 2;
    localparam int CFG_IDX_W     = 3;

    localparam logic [TIME_W-1:0]    MODULUS_RST = 32'd65536;
    localparam logic [TIME_W-1:0]    MODULUS_MIN = 32'd4;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 31'd1000;
    localparam logic [TICK_W-1:0]    TICK_START  = 32'h0000_0001;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK0   = 3'd2;

    typedef enum logic [1:0] {
        KIND_TIME    = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // item leaving the reduction pipe, valid only on the cycle it retires
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [TIDX_W-1:0]  tidx;
        logic [TIME_W-1:0]  red_a;   // sample_time or stop_time mod M
        logic [TIME_W-1:0]  red_b;   // start_time mod M
    } step_t;

    typedef struct packed {
        logic [TIME_W-1:0]   modulus;
        logic [PERIOD_W-1:0] period;
        logic                bad;
    } time_cfg_t;

    typedef struct packed {
        logic                 fired;
        logic [MAX_TASKS-1:0] run;
        logic [TICK_W-1:0]    word;
    } tick_res_t;

    typedef struct packed {
        logic              updated;
        logic [TIME_W-1:0] avg;
        logic [TIME_W-1:0] worst;
    } stats_res_t;

    // one restoring step of a remainder: shift in a bit, subtract M once
    function automatic logic [TIME_W-1:0] mod_step(
        input logic [TIME_W-1:0] rem,
        input logic              din,
        input logic [TIME_W-1:0] m
    );
        logic [TIME_W:0] sh;
        sh = {rem, din};
        if (sh >= {1'b0, m})
        begin
            sh = sh - {1'b0, m};
        end
        return sh[TIME_W-1:0];
    endfunction

    // (a - b) mod M for a, b already below M
    function automatic logic [TIME_W-1:0] mod_sub(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b,
        input logic [TIME_W-1:0] m
    );
        logic [TIME_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[TIME_W])
        begin
            d = d + {1'b0, m};
        end
        return d[TIME_W-1:0];
    endfunction

    // (a + p) mod M for a below M and p below M/2
    function automatic logic [TIME_W-1:0] mod_add(
        input logic [TIME_W-1:0]   a,
        input logic [PERIOD_W-1:0] p,
        input logic [TIME_W-1:0]   m
    );
        logic [TIME_W:0] s;
        s = {1'b0, a} + {2'b00, p};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[TIME_W-1:0];
    endfunction

endpackage

[hw/rtl/tick_mask_task_scheduler_core.sv]
// Pipe: input register, 32 remainder stages, result register.
// Throughput: one item per cycle while item_stall is low; the 32-stage remainder
//   pipe sets the latency.
// A time_modulus write holds item_stall high while the stored last tick time is
//   reduced by the new modulus, one bit per cycle.
// Reset (rst_n, async, active low): empties the pipe and result register, restores
//   the registers to their defaults, clears tick state and all task statistics.
module tick_mask_task_scheduler_core
    import tmts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // item channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            kind,
    input  logic [TIME_W-1:0]     sample_time,
    input  logic [TIDX_W-1:0]     task_index,
    input  logic [TIME_W-1:0]     start_time,
    input  logic [TIME_W-1:0]     stop_time,

    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  tick_fired,
    output logic [MAX_TASKS-1:0]  run_mask,
    output logic [TICK_W-1:0]     tick_word,
    output logic                  stats_updated,
    output logic [TIME_W-1:0]     mean_exec_time,
    output logic [TIME_W-1:0]     worst_time,
    output logic                  config_bad,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);

    // configuration registers
    logic [TIME_W-1:0]                modulus_reg;
    logic [PERIOD_W-1:0]              period_reg;
    logic [NUM_TASKS-1:0][TICK_W-1:0] mask_reg;

    logic       cfg_wr, modulus_wr;
    time_cfg_t  tcfg;

    // pipe control
    logic       en, accept, busy;
    step_t      step;
    tick_res_t  tick_res;
    stats_res_t stats_res;

    // result register
    logic                  result_valid_reg, result_valid_next;
    logic                  fired_reg;
    logic [MAX_TASKS-1:0]  run_reg;
    logic [TICK_W-1:0]     word_reg;
    logic                  upd_reg;
    logic [TIME_W-1:0]     avg_reg;
    logic [TIME_W-1:0]     worst_reg;
    logic                  bad_reg;

    // Configuration is always taken; writes past the last register drop silently.
    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign modulus_wr = cfg_wr && (cfg_index == CFG_MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RST;
            period_reg  <= PERIOD_RST;
            mask_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_PERIOD:  period_reg  <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                    for (int i = 0; i < NUM_TASKS; i++)
                    begin
                        if (cfg_index == CFG_IDX_W'(CFG_MASK0 + i))
                        begin
                            mask_reg[i] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // A bad setup blocks samples and reports but still lets restart and clear act.
    always_comb
    begin
        tcfg.modulus = modulus_reg;
        tcfg.period  = period_reg;
        tcfg.bad     = (modulus_reg < MODULUS_MIN) || (period_reg == '0)
                       || ({1'b0, period_reg} >= (modulus_reg >> 1));
    end

    // The whole pipe advances together whenever the result register can take
    // the item at its end: empty, or being drained this cycle.
    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en || busy;
    assign accept     = item_valid && !item_stall;

    // Reduce sample, start and stop times modulo M, one bit per stage.
    tmts_mod_pipe u_mod_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .load        (accept),
        .kind        (kind_t'(kind)),
        .sample_time (sample_time),
        .task_index  (task_index),
        .start_time  (start_time),
        .stop_time   (stop_time),
        .modulus     (modulus_reg),
        .step        (step)
    );

    // Tick decision and rotation; owns the last tick time and its re-reduction.
    tmts_tick_unit #(
        .NUM_TASKS (NUM_TASKS)
    ) u_tick_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .tcfg       (tcfg),
        .modulus_wr (modulus_wr),
        .mask       (mask_reg),
        .busy       (busy),
        .res        (tick_res)
    );

    // Per-task halving average and worst case.
    tmts_stats_unit #(
        .NUM_TASKS (NUM_TASKS)
    ) u_stats_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .tcfg  (tcfg),
        .res   (stats_res)
    );

    // Hold the result until taken; refill from the end of the pipe.
    assign result_valid_next = en ? (step.valid) : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            fired_reg <= tick_res.fired;
            run_reg   <= tick_res.run;
            word_reg  <= tick_res.word;
            upd_reg   <= stats_res.updated;
            avg_reg   <= stats_res.avg;
            worst_reg <= stats_res.worst;
            bad_reg   <= tcfg.bad;
        end
    end

    assign result_valid   = result_valid_reg;
    assign tick_fired     = fired_reg;
    assign run_mask       = run_reg;
    assign tick_word      = word_reg;
    assign stats_updated  = upd_reg;
    assign mean_exec_time = avg_reg;
    assign worst_time     = worst_reg;
    assign config_bad     = bad_reg;

endmodule

[hw/rtl/tmts_mod_pipe.sv]
module tmts_mod_pipe
    import tmts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              load,
    input  kind_t             kind,
    input  logic [TIME_W-1:0] sample_time,
    input  logic [TIDX_W-1:0] task_index,
    input  logic [TIME_W-1:0] start_time,
    input  logic [TIME_W-1:0] stop_time,
    input  logic [TIME_W-1:0] modulus,
    output step_t             step
);

    localparam int STAGES = TIME_W;

    logic [STAGES:0]   v_reg;
    kind_t             kind_reg  [STAGES+1];
    logic [TIDX_W-1:0] tidx_reg  [STAGES+1];
    logic [TIME_W-1:0] src_a_reg [STAGES];
    logic [TIME_W-1:0] src_b_reg [STAGES];
    logic [TIME_W-1:0] rem_a_reg [STAGES+1];
    logic [TIME_W-1:0] rem_b_reg [STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-1:0], load};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // input register: lane A takes the sample or the stop time
            kind_reg[0]  <= kind;
            tidx_reg[0]  <= task_index;
            src_a_reg[0] <= (kind == KIND_TIME) ? sample_time : stop_time;
            src_b_reg[0] <= start_time;
            rem_a_reg[0] <= '0;
            rem_b_reg[0] <= '0;
            // one remainder bit per stage, most significant first
            for (int k = 1; k <= STAGES; k++)
            begin
                kind_reg[k]  <= kind_reg[k-1];
                tidx_reg[k]  <= tidx_reg[k-1];
                rem_a_reg[k] <= mod_step(rem_a_reg[k-1], src_a_reg[k-1][STAGES-k], modulus);
                rem_b_reg[k] <= mod_step(rem_b_reg[k-1], src_b_reg[k-1][STAGES-k], modulus);
            end
            for (int k = 1; k < STAGES; k++)
            begin
                src_a_reg[k] <= src_a_reg[k-1];
                src_b_reg[k] <= src_b_reg[k-1];
            end
        end
    end

    always_comb
    begin
        step.valid = v_reg[STAGES] && en;
        step.kind  = kind_reg[STAGES];
        step.tidx  = tidx_reg[STAGES];
        step.red_a = rem_a_reg[STAGES];
        step.red_b = rem_b_reg[STAGES];
    end

endmodule

[hw/rtl/tmts_tick_unit.sv]
`include "tick_mask_task_scheduler_core_defines.svh"

module tmts_tick_unit
    import tmts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  step_t                           step,
    input  time_cfg_t                       tcfg,
    input  logic                            modulus_wr,
    input  logic [NUM_TASKS-1:0][TICK_W-1:0] mask,
    output logic                            busy,
    output tick_res_t                       res
);

    localparam int                CNT_W     = $clog2(TIME_W + 1);
    localparam logic [CNT_W-1:0]  RED_STEPS = CNT_W'(TIME_W);
    localparam logic [CNT_W-1:0]  RED_LAST  = CNT_W'(1);

    logic [TICK_W-1:0]    tick_bit_reg, tick_bit_next;
    logic [TIME_W-1:0]    lt_reg, lt_next;
    // last tick time as set by the last tick, re-reduced into lt_reg per modulus write
    logic [TIME_W-1:0]    lt_raw_reg, lt_raw_next;
    logic [CNT_W-1:0]     red_cnt_reg, red_cnt_next;
    logic [TIME_W-1:0]    red_src_reg;
    logic [TIME_W-1:0]    red_rem_reg, red_rem_next;

    logic [TIME_W-1:0]    half, delta, lt_adv;
    logic [TICK_W-1:0]    word;
    logic                 first, back, due, fire, sample_ok;
    logic [MAX_TASKS-1:0] run;

    assign busy = (red_cnt_reg != '0);

    always_comb
    begin
        half      = tcfg.modulus >> 1;
        delta     = mod_sub(step.red_a, lt_reg, tcfg.modulus);
        first     = (tick_bit_reg == '0);
        back      = (delta >= half);
        due       = (delta >= {1'b0, tcfg.period});
        fire      = first || back || due;
        word      = first ? TICK_START : tick_bit_reg;
        lt_adv    = mod_add(lt_reg, tcfg.period, tcfg.modulus);
        sample_ok = step.valid && (step.kind == KIND_TIME) && !tcfg.bad;

        run = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            run[i] = fire ? (|(mask[i] & word)) : (mask[i] == '0);
        end

        red_rem_next = mod_step(red_rem_reg, red_src_reg[TIME_W-1], tcfg.modulus);
        red_cnt_next = busy ? (red_cnt_reg - RED_LAST) : red_cnt_reg;
        if (modulus_wr)
        begin
            red_cnt_next = RED_STEPS;
        end

        tick_bit_next = tick_bit_reg;
        lt_next       = lt_reg;
        lt_raw_next   = lt_raw_reg;
        if (sample_ok && fire)
        begin
            tick_bit_next = {word[TICK_W-2:0], word[TICK_W-1]};
            lt_next       = (first || back) ? step.red_a : lt_adv;
            lt_raw_next   = lt_next;
        end
        if (step.valid && (step.kind == KIND_RESTART))
        begin
            tick_bit_next = '0;
        end
        // re-reduced last tick time lands at the end of the pass
        if (red_cnt_reg == RED_LAST)
        begin
            lt_next = red_rem_next;
        end

        res.fired = sample_ok && fire;
        res.run   = sample_ok ? run : '0;
        res.word  = (sample_ok && fire) ? word : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_bit_reg <= '0;
            lt_reg       <= '0;
            lt_raw_reg   <= '0;
            red_cnt_reg  <= '0;
        end
        else
        begin
            tick_bit_reg <= tick_bit_next;
            lt_reg       <= lt_next;
            lt_raw_reg   <= lt_raw_next;
            red_cnt_reg  <= red_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (modulus_wr)
        begin
            red_src_reg <= lt_raw_reg;
            red_rem_reg <= '0;
        end
        else if (busy)
        begin
            red_src_reg <= {red_src_reg[TIME_W-2:0], 1'b0};
            red_rem_reg <= red_rem_next;
        end
    end

    `TMTS_ASSERT_NEXT(a_reduce_starts, clk, rst_n, modulus_wr, busy)
    `TMTS_ASSERT_NOW(a_tick_bit_onehot0, clk, rst_n, 1'b1, $onehot0(tick_bit_reg))
    `TMTS_ASSERT_NEXT(a_fire_arms_tick, clk, rst_n, res.fired, tick_bit_reg != '0)
    `TMTS_ASSERT_NOW(a_fired_word_onehot, clk, rst_n, res.fired, $onehot(res.word))

endmodule

[hw/rtl/tmts_stats_unit.sv]
module tmts_stats_unit
    import tmts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_t      step,
    input  time_cfg_t  tcfg,
    output stats_res_t res
);

    localparam int                IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [TIDX_W:0]   TASKS = (TIDX_W + 1)'(NUM_TASKS);

    logic [TIME_W-1:0] avg_reg   [NUM_TASKS];
    logic [TIME_W-1:0] worst_reg [NUM_TASKS];

    logic [IDX_W-1:0]  idx;
    logic              hit, ok, clear;
    logic [TIME_W-1:0] half, et, cur_avg, cur_worst, avg_new, worst_new;
    logic [TIME_W:0]   sum;

    always_comb
    begin
        idx       = step.tidx[IDX_W-1:0];
        hit       = step.valid && (step.kind == KIND_REPORT) && !tcfg.bad
                    && ({1'b0, step.tidx} < TASKS);
        clear     = step.valid && (step.kind == KIND_CLEAR);
        half      = tcfg.modulus >> 1;
        et        = mod_sub(step.red_a, step.red_b, tcfg.modulus);
        ok        = (et < half);
        cur_avg   = avg_reg[idx];
        cur_worst = worst_reg[idx];
        sum       = {1'b0, cur_avg} + {1'b0, et};
        avg_new   = sum[TIME_W:1];
        worst_new = (et > cur_worst) ? et : cur_worst;

        res.updated = hit && ok;
        res.avg     = hit ? (ok ? avg_new : cur_avg) : '0;
        res.worst   = hit ? (ok ? worst_new : cur_worst) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                avg_reg[i]   <= '0;
                worst_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                avg_reg[i]   <= '0;
                worst_reg[i] <= '0;
            end
        end
        else if (hit && ok)
        begin
            avg_reg[idx]   <= avg_new;
            worst_reg[idx] <= worst_new;
        end
    end

endmodule

[verif/tick_mask_task_scheduler_core_test.sv]
`timescale 1ns / 1ps

module tick_mask_task_scheduler_core_test;
    import tmts_pkg::*;

    // The slowest correct run stays far below this: about 800 items, each with its idle
    // gap, a stalled result and the pipe, plus a drain before every register setting.
    localparam int CYCLE_LIMIT  = 200000;
    // The result register sits behind the input register and the remainder stages.
    localparam int DRAIN_CYCLES = 40;

    // One expected result: the dispatch decision and the statistics of one item.
    typedef struct packed {
        logic                 fired;
        logic [MAX_TASKS-1:0] run;
        logic [TICK_W-1:0]    word;
        logic                 updated;
        logic [TIME_W-1:0]    avg;
        logic [TIME_W-1:0]    worst;
        logic                 bad;
    } dispatch_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;

    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    logic [1:0]            kind         = '0;
    logic [TIME_W-1:0]     sample_time  = '0;
    logic [TIDX_W-1:0]     task_index   = '0;
    logic [TIME_W-1:0]     start_time   = '0;
    logic [TIME_W-1:0]     stop_time    = '0;

    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  tick_fired;
    logic [MAX_TASKS-1:0]  run_mask;
    logic [TICK_W-1:0]     tick_word;
    logic                  stats_updated;
    logic [TIME_W-1:0]     mean_exec_time;
    logic [TIME_W-1:0]     worst_time;
    logic                  config_bad;

    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [TIME_W-1:0]     cfg_data     = '0;

    // Shadow copy of the registers and of the scheduler state.
    logic [TIME_W-1:0]     time_mod_r;
    logic [PERIOD_W-1:0]   period_r;
    logic [TICK_W-1:0]     mask_r [MAX_TASKS];
    logic [TICK_W-1:0]     tick_bit_r;
    logic [TIME_W-1:0]     last_tick_r;
    logic [TIME_W-1:0]     avg_r [MAX_TASKS];
    logic [TIME_W-1:0]     worst_r [MAX_TASKS];

    dispatch_t             expected_dispatch [$];

    int                    error_count     = 0;
    int                    items_sent      = 0;
    int                    ticks_seen      = 0;
    int                    reports_applied = 0;
    int                    ignored_items   = 0;
    int                    settings_used   = 0;
    int                    burst_left      = 0;
    int unsigned           cycle_count     = 0;
    int                    stall_mode      = 0;
    int                    stall_timer     = 0;
    logic [TIME_W-1:0]     time_cursor     = '0;

    tick_mask_task_scheduler_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .sample_time    (sample_time),
        .task_index     (task_index),
        .start_time     (start_time),
        .stop_time      (stop_time),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .tick_fired     (tick_fired),
        .run_mask       (run_mask),
        .tick_word      (tick_word),
        .stats_updated  (stats_updated),
        .mean_exec_time (mean_exec_time),
        .worst_time     (worst_time),
        .config_bad     (config_bad),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Count cycles and stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_dispatch.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the result channel on a pattern drawn anew whenever its timer runs out:
    // never, at random, short periodic stalls, or longer periodic stretches.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 300);
        end
        else
        begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 2) == 0);
            2:       result_stall <= ((cycle_count % 8) < 3);
            default: result_stall <= ((cycle_count % 32) >= 22);
        endcase
    end

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            error_count++;
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_dispatch.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual word %h",
                         $time, tick_word);
                error_count++;
            end
            else
            begin
                want = expected_dispatch.pop_front();
                check_field("tick_fired", want.fired, tick_fired);
                check_field("run_mask", want.run, run_mask);
                check_field("tick_word", want.word, tick_word);
                check_field("stats_updated", want.updated, stats_updated);
                check_field("mean_exec_time", want.avg, mean_exec_time);
                check_field("worst_time", want.worst, worst_time);
                check_field("config_bad", want.bad, config_bad);
            end
        end
    end

    function automatic bit config_is_bad();
        return (time_mod_r < MODULUS_MIN) || (period_r == '0) ||
               ({1'b0, period_r} >= (time_mod_r >> 1));
    endfunction

    // Signed a - b on the time circle; both already reduced.
    function automatic longint signed_lag(input logic [31:0] a, input logic [31:0] b);
        longint m;
        longint d;
        m = {32'b0, time_mod_r};
        d = ({32'b0, a} + m - {32'b0, b}) % m;
        if (d < (m >>> 1))
        begin
            return d;
        end
        return d - m;
    endfunction

    // Advance the shadow scheduler by one item and return what the block must give.
    function automatic dispatch_t schedule_step(input kind_t k, input logic [31:0] smp,
                                                input logic [1:0] tix, input logic [31:0] t0,
                                                input logic [31:0] t1);
        dispatch_t   res;
        logic [31:0] now;
        longint      lag;
        bit          fire;
        int          i;
        res      = '0;
        res.bad  = config_is_bad();
        fire     = 1'b0;
        case (k)
            KIND_TIME:
            begin
                if (!res.bad)
                begin
                    now = smp % time_mod_r;
                    if (tick_bit_r == '0)
                    begin
                        // first sample after reset or restart
                        tick_bit_r  = TICK_START;
                        last_tick_r = now;
                        fire        = 1'b1;
                    end
                    else
                    begin
                        lag = signed_lag(now, last_tick_r % time_mod_r);
                        if (lag < 0)
                        begin
                            // time stepped backward: resync
                            last_tick_r = now;
                            fire        = 1'b1;
                        end
                        else if (lag >= period_r)
                        begin
                            last_tick_r = 32'(({32'b0, last_tick_r % time_mod_r} +
                                               {33'b0, period_r}) % {32'b0, time_mod_r});
                            fire        = 1'b1;
                        end
                    end
                    if (fire)
                    begin
                        res.fired = 1'b1;
                        res.word  = tick_bit_r;
                        for (i = 0; i < MAX_TASKS; i++)
                        begin
                            if ((mask_r[i] & tick_bit_r) != '0)
                            begin
                                res.run[i] = 1'b1;
                            end
                        end
                        tick_bit_r = {tick_bit_r[TICK_W-2:0], tick_bit_r[TICK_W-1]};
                    end
                    else
                    begin
                        for (i = 0; i < MAX_TASKS; i++)
                        begin
                            if (mask_r[i] == '0)
                            begin
                                res.run[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_REPORT:
            begin
                if (!res.bad)
                begin
                    lag = signed_lag(t1 % time_mod_r, t0 % time_mod_r);
                    if (lag >= 0)
                    begin
                        avg_r[tix] = 32'(({32'b0, avg_r[tix]} + lag) >> 1);
                        if (lag > {32'b0, worst_r[tix]})
                        begin
                            worst_r[tix] = 32'(lag);
                        end
                        res.updated = 1'b1;
                    end
                    res.avg   = avg_r[tix];
                    res.worst = worst_r[tix];
                end
            end
            KIND_RESTART:
            begin
                tick_bit_r = '0;
            end
            default:
            begin
                for (i = 0; i < MAX_TASKS; i++)
                begin
                    avg_r[i]   = '0;
                    worst_r[i] = '0;
                end
            end
        endcase
        return res;
    endfunction

    // Drive one item and hold it until accepted; work in bursts with random gaps.
    task automatic send_item(input kind_t k, input logic [31:0] smp, input logic [1:0] tix,
                             input logic [31:0] t0, input logic [31:0] t1);
        dispatch_t res;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid  <= 1'b1;
        kind        <= k;
        sample_time <= smp;
        task_index  <= tix;
        start_time  <= t0;
        stop_time   <= t1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        res = schedule_step(k, smp, tix, t0, t1);
        expected_dispatch.push_back(res);
        items_sent++;
        if (res.fired)
        begin
            ticks_seen++;
        end
        if (res.updated)
        begin
            reports_applied++;
        end
        if (res.bad && (k == KIND_TIME || k == KIND_REPORT))
        begin
            ignored_items++;
        end
    endtask

    task automatic sample_at(input logic [31:0] t);
        send_item(KIND_TIME, t, 2'($urandom), $urandom, $urandom);
    endtask

    task automatic report_run(input logic [1:0] tix, input logic [31:0] t0,
                              input logic [31:0] t1);
        send_item(KIND_REPORT, $urandom, tix, t0, t1);
    endtask

    task automatic send_control(input kind_t k);
        send_item(k, $urandom, 2'($urandom), $urandom, $urandom);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        burst_left  = 0;
        while (expected_dispatch.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_MODULUS: time_mod_r = data;
            CFG_PERIOD:  period_r   = data[PERIOD_W-1:0];
            default:     mask_r[idx - CFG_MASK0] = data;
        endcase
    endtask

    // Write all registers while the block is idle.
    task automatic apply_setting(input logic [31:0] modulus, input logic [31:0] period,
                                 input logic [31:0] m0, input logic [31:0] m1,
                                 input logic [31:0] m2, input logic [31:0] m3);
        drain_results();
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_MASK0, m0);
        write_reg(CFG_MASK0 + 3'd1, m1);
        write_reg(CFG_MASK0 + 3'd2, m2);
        write_reg(CFG_MASK0 + 3'd3, m3);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [31:0] random_mask();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'h1 << $urandom_range(0, 31);
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Now and then add whole multiples of the modulus so the block must reduce.
    function automatic logic [31:0] lift_out_of_range(input logic [31:0] v);
        longint unsigned room;
        longint unsigned mult;
        if (time_mod_r == '0)
        begin
            return v;
        end
        room = (64'hFFFF_FFFF - v) / time_mod_r;
        if (room == 0 || $urandom_range(0, 3) != 0)
        begin
            return v;
        end
        mult = $urandom_range(1, 32'(room));
        return 32'({32'b0, v} + {32'b0, time_mod_r} * mult);
    endfunction

    // Reset defaults: first sample fires bit 0, period boundary, backward step,
    // wrap of an out-of-range sample, restart, idle tasks.
    task automatic test_tick_rules();
        sample_at(100);
        sample_at(600);
        sample_at(1100);
        sample_at(1099);
        apply_setting(MODULUS_RST, PERIOD_RST, 32'h1, 32'h6, 32'h8000_0000, 32'h0);
        sample_at(32'hFFFF_FFFF);
        send_control(KIND_RESTART);
        sample_at(0);
        sample_at(999);
    endtask

    // Halving average and maximum: positive, negative, zero and wrapped times,
    // largest positive difference, clear.
    task automatic test_execution_stats();
        report_run(0, 10, 110);
        report_run(0, 200, 100);
        report_run(0, 5, 5);
        report_run(3, 65000, 100);
        report_run(1, 32'hFFFF_FFFF, 0);
        report_run(2, 0, 32767);
        send_control(KIND_CLEAR);
        report_run(2, 0, 32768);
    endtask

    // Invalid settings ignore samples and reports but still restart and clear;
    // probe the extremes of modulus and period on both sides of the limit.
    task automatic test_config_checks();
        apply_setting(3, 1, random_mask(), random_mask(), random_mask(), random_mask());
        sample_at(1);
        report_run(1, 0, 1);
        send_control(KIND_RESTART);
        send_control(KIND_CLEAR);
        apply_setting(MODULUS_MIN, 32'h8000_0001, 32'h1, 32'h2, 32'h0, 32'hFFFF_FFFF);
        sample_at(2);
        report_run(3, 3, 0);
        apply_setting(64, 32, random_mask(), random_mask(), random_mask(), random_mask());
        sample_at(40);
        apply_setting(32'hFFFF_FFFF, 0, random_mask(), random_mask(), random_mask(),
                      random_mask());
        sample_at(7);
        apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, random_mask(), random_mask(),
                      random_mask(), random_mask());
        sample_at(9);
        apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFE, random_mask(), random_mask(),
                      random_mask(), random_mask());
        sample_at(32'hFFFF_FFFF);
    endtask

    // Random traffic under the current setting. Samples mostly walk forward around
    // the period so ticks fire and rotate; the rest jump far, step backward or are raw.
    task automatic run_traffic_phase(input int n_items, input int restart_pct);
        int              n;
        int              r;
        kind_t           k;
        longint unsigned m;
        longint unsigned p;
        longint unsigned span;
        longint unsigned step;
        logic [31:0]     smp;
        logic [31:0]     t0;
        logic [31:0]     t1;
        m           = (time_mod_r == '0) ? 1 : time_mod_r;
        p           = (period_r == '0) ? 1 : period_r;
        span        = ((m >> 1) == 0) ? 1 : (m >> 1);
        time_cursor = 32'($urandom % m);
        for (n = 0; n < n_items; n++)
        begin
            r   = $urandom_range(0, 99);
            smp = $urandom;
            t0  = $urandom;
            t1  = $urandom;
            if (r < 55)
            begin
                k = KIND_TIME;
                r = $urandom_range(0, 99);
                if (r < 92)
                begin
                    if (r < 40)
                        step = $urandom % p;
                    else if (r < 70)
                        step = p - 1 + $urandom_range(0, 2);
                    else if (r < 82)
                        step = $urandom % span;
                    else
                        step = m - 1 - ($urandom % p);
                    time_cursor = 32'((time_cursor + step) % m);
                    smp         = lift_out_of_range(time_cursor);
                end
                else
                begin
                    time_cursor = 32'(smp % m);
                end
            end
            else if (r < 90)
            begin
                k = KIND_REPORT;
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    t0 = 32'($urandom % m);
                    if (r < 55)
                        step = $urandom % ((span < 5000) ? span : 5000);
                    else if (r < 70)
                        step = $urandom % span;
                    else
                        step = m - 1 - ($urandom % ((span < 1000) ? span : 1000));
                    t1 = lift_out_of_range(32'((t0 + step) % m));
                    t0 = lift_out_of_range(t0);
                end
            end
            else if (r < 90 + restart_pct)
            begin
                k = KIND_RESTART;
            end
            else
            begin
                k = KIND_CLEAR;
            end
            send_item(k, smp, 2'($urandom), t0, t1);
        end
    endtask

    // Walk through a list of settings: extremes, then random ones, then two fixed ones.
    task automatic test_random_traffic();
        int          ph;
        int          n;
        int          rp;
        logic [31:0] modulus;
        logic [31:0] period;
        for (ph = 0; ph < 12; ph++)
        begin
            n  = 58;
            rp = 4;
            case (ph)
                0:
                begin
                    modulus = MODULUS_RST;
                    period  = PERIOD_RST;
                end
                1:
                begin
                    // tiny circle, no restarts: the tick word wraps all the way round
                    modulus = MODULUS_MIN;
                    period  = 1;
                    n       = 100;
                    rp      = 0;
                end
                2:
                begin
                    modulus = 5;
                    period  = 1;
                end
                3:
                begin
                    modulus = 37;
                    period  = 17;
                end
                4:
                begin
                    modulus = 1000;
                    period  = 499;
                end
                5:
                begin
                    modulus = 32'hFFFF_FFFF;
                    period  = 32'h7FFF_FFFE;
                end
                6:
                begin
                    modulus = 32'hFFFF_FFFF;
                    period  = 1;
                end
                7:
                begin
                    modulus = 32'h8000_0000;
                    period  = $urandom_range(1, 32'h3FFF_FFFF);
                end
                8:
                begin
                    modulus = $urandom_range(4, 200);
                    period  = $urandom_range(1, (modulus >> 1) - 1);
                end
                9:
                begin
                    modulus = $urandom_range(4, 32'hFFFF_FFFF);
                    period  = $urandom_range(1, (modulus >> 1) - 1);
                end
                10:
                begin
                    // period equal to half the modulus: invalid
                    modulus = 64;
                    period  = 32;
                    n       = 20;
                end
                default:
                begin
                    modulus = 256;
                    period  = 1;
                    n       = 100;
                    rp      = 0;
                end
            endcase
            // bit 31 of the period write is not part of the register
            period = period | (32'($urandom_range(0, 1)) << 31);
            apply_setting(modulus, period, random_mask(), random_mask(), random_mask(),
                          random_mask());
            run_traffic_phase(n, rp);
        end
    endtask

    initial
    begin
        int i;
        time_mod_r  = MODULUS_RST;
        period_r    = PERIOD_RST;
        tick_bit_r  = '0;
        last_tick_r = '0;
        for (i = 0; i < MAX_TASKS; i++)
        begin
            mask_r[i]  = '0;
            avg_r[i]   = '0;
            worst_r[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tick_rules();
        test_execution_stats();
        test_config_checks();
        test_random_traffic();

        // hold until every result is back, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items under %0d register settings in %0d cycles.",
                 items_sent, settings_used, cycle_count);
        $display("Ticks fired %0d, reports applied %0d, items ignored by bad setting %0d.",
                 ticks_seen, reports_applied, ignored_items);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
